### src/priority_band_table_defines.svh
// Assertion macros used by the port-level checker.
`ifndef PRIORITY_BAND_TABLE_DEFINES_SVH
`define PRIORITY_BAND_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PBT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/pbt_pkg.sv
// Shared constants, request codes and divider types for the priority band table.
`default_nettype none
package pbt_pkg;
    localparam int ROWS_DEF       = 200;
    localparam int BOUNDARY_COUNT = 14;
    localparam int SCALE          = 2000;
    localparam int TOP_BAND       = 15;
    localparam int PRI_W          = 5;
    localparam int ROW_W          = 8;
    localparam int DIV_W          = 19;
    localparam int DCNT_W         = $clog2(DIV_W + 1);

    localparam logic [1:0] REQ_BUILD = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_R2P   = 2'd2;
    localparam logic [1:0] REQ_P2R   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

### src/pbt_if.sv
// Request and response channel interfaces of the priority band table.
`default_nettype none
interface pbt_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [3:0]        band_count;
    logic              keep_count;
    logic [7:0]        top_row;
    logic [7:0]        bottom_row;
    logic [7:0]        boundary;
    logic signed [9:0] row_in;
    logic [4:0]        priority_in;

    modport source (output valid, req_type, band_count, keep_count, top_row, bottom_row,
                    boundary, row_in, priority_in, input ready);
    modport sink (input valid, req_type, band_count, keep_count, top_row, bottom_row,
                  boundary, row_in, priority_in, output ready);
endinterface

interface pbt_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] priority_out;
    logic [7:0] row_out;
    logic [1:0] status;

    modport source (output valid, priority_out, row_out, status, input ready);
    modport sink (input valid, priority_out, row_out, status, output ready);
endinterface
`default_nettype wire

### src/pbt_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module pbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### src/pbt_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pbt_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pbt_pkg::t_div_req i_req,
    output pbt_pkg::t_div_rsp      o_rsp
);
    import pbt_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W:0]    r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_dvs;
    logic [DIV_W:0]    sh;
    logic              ge;

    always_comb begin
        sh = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
        ge = (sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (sh - {1'b0, r_dvs}) : sh;
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

### src/priority_band_table.sv
// Top level of the priority band table: sequencer, table RAM and divider.
//
// The row table sits in one single-port RAM of ROWS five-bit entries. One request
// is worked at a time; a new request is taken while the previous response still
// waits at the output register. A row-to-priority query reads one table entry; a
// priority-to-row query scans rows from row 0 up to the stored bottom; a load byte
// fills rows up to its boundary; a build divides for the band span and, if the area
// is not empty, for the last banded row, then writes rows outside the band area
// directly and runs one division per row inside it on the shared bit-serial divider.
// Rejected builds answer without touching the table. Queries are valid only after
// a complete build or load has written the table.
`default_nettype none
module priority_band_table #(
    parameter int ROWS = pbt_pkg::ROWS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pbt_req_if.sink   i_req,
    pbt_rsp_if.source o_rsp
);
    import pbt_pkg::*;

    localparam int RW = $clog2(ROWS + 1);
    localparam int AW = $clog2(ROWS);
    localparam int CW = (RW > 8) ? RW : 8;
    localparam int QW = ((RW > 10) ? RW : 10) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPAN  = 4'd1;
    localparam logic [3:0] S_LAST  = 4'd2;
    localparam logic [3:0] S_FILL  = 4'd3;
    localparam logic [3:0] S_FDIV  = 4'd4;
    localparam logic [3:0] S_LOAD  = 4'd5;
    localparam logic [3:0] S_REST  = 4'd6;
    localparam logic [3:0] S_RQ    = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SCK   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [RW-1:0]    r_area_top, n_area_top;
    logic [RW-1:0]    r_area_bot, n_area_bot;
    logic [3:0]       r_stored, n_stored;
    logic [RW-1:0]    r_load_row, n_load_row;
    logic [3:0]       r_load_band, n_load_band;
    logic [RW-1:0]    r_y, n_y;
    logic [RW-1:0]    r_top, n_top;
    logic [RW-1:0]    r_bot, n_bot;
    logic [RW-1:0]    r_lim, n_lim;
    logic [3:0]       r_cnt, n_cnt;
    logic [7:0]       r_d, n_d;
    logic [DIV_W-1:0] r_span, n_span;
    logic             r_fix, n_fix;
    logic [PRI_W-1:0] r_p, n_p;
    logic [PRI_W-1:0] r_res_pri, n_res_pri;
    logic [ROW_W-1:0] r_res_row, n_res_row;
    logic [1:0]       r_res_st, n_res_st;
    logic             r_out_valid;
    logic [PRI_W-1:0] r_out_pri;
    logic [ROW_W-1:0] r_out_row;
    logic [1:0]       r_out_st;

    logic             fire;
    logic             push;
    logic [CW-1:0]    rows_c, top_c, bot_c, lim_c, d_c, yt_c;
    logic [RW-1:0]    top_s, bot_s, lim_s;
    logic [3:0]       cnt_c;
    logic [QW-1:0]    ys, at_s, ab_s, sel;
    logic [AW-1:0]    q_idx;
    logic [DIV_W-1:0] span_c;
    logic [PRI_W-1:0] fval;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [PRI_W-1:0] mem_wdata;
    logic [PRI_W-1:0] mem_rdata;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    pbt_ram #(.WIDTH(PRI_W), .DEPTH(ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    pbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign fire        = i_req.valid && i_req.ready;
    assign push        = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // Saturate request rows to the table size and pick the band count.
    always_comb begin
        rows_c = CW'(ROWS);
        top_c  = CW'(i_req.top_row);
        bot_c  = CW'(i_req.bottom_row);
        lim_c  = CW'(i_req.boundary);
        top_s  = RW'((top_c > rows_c) ? rows_c : top_c);
        bot_s  = RW'((bot_c > rows_c) ? rows_c : bot_c);
        lim_s  = RW'((lim_c > rows_c) ? rows_c : lim_c);
        cnt_c  = i_req.keep_count ? r_stored : i_req.band_count;
        d_c    = CW'(bot_s) - CW'(top_s);
        yt_c   = CW'(r_y - r_top);
        span_c = (div_rsp.quotient == '0) ? DIV_W'(1) : div_rsp.quotient;
        fval   = PRI_W'(div_rsp.quotient + 1'b1);
        if (r_fix && fval == PRI_W'(TOP_BAND)) begin
            fval = PRI_W'(TOP_BAND - 1);
        end
    end

    // Clamp the query row to the stored band area.
    always_comb begin
        ys   = QW'(i_req.row_in);
        at_s = QW'(r_area_top);
        ab_s = QW'(r_area_bot);
        if ($signed(ys) < $signed(at_s)) begin
            sel = at_s;
        end else if ($signed(ys) > $signed(ab_s)) begin
            sel = ab_s;
        end else begin
            sel = ys;
        end
        if (sel >= QW'(ROWS)) begin
            sel = QW'(ROWS - 1);
        end
        q_idx = AW'(sel);
    end

    always_comb begin
        n_state     = r_state;
        n_area_top  = r_area_top;
        n_area_bot  = r_area_bot;
        n_stored    = r_stored;
        n_load_row  = r_load_row;
        n_load_band = r_load_band;
        n_y         = r_y;
        n_top       = r_top;
        n_bot       = r_bot;
        n_lim       = r_lim;
        n_cnt       = r_cnt;
        n_d         = r_d;
        n_span      = r_span;
        n_fix       = r_fix;
        n_p         = r_p;
        n_res_pri   = r_res_pri;
        n_res_row   = r_res_row;
        n_res_st    = r_res_st;
        mem_we      = 1'b0;
        mem_addr    = AW'(r_y);
        mem_wdata   = '0;
        div_req     = '{start: 1'b0, dividend: '0, divisor: '0};

        case (r_state)
            S_IDLE: begin
                mem_addr = q_idx;
                if (fire) begin
                    n_res_pri = '0;
                    n_res_row = '0;
                    n_res_st  = ST_OK;
                    case (i_req.req_type)
                        REQ_BUILD: begin
                            if (cnt_c == '0) begin
                                n_res_st = ST_ZERO;
                                n_state  = S_DONE;
                            end else if (bot_s < top_s) begin
                                n_res_st = ST_ORDER;
                                n_state  = S_DONE;
                            end else begin
                                n_load_row  = '0;
                                n_load_band = '0;
                                n_stored    = cnt_c;
                                n_cnt       = cnt_c;
                                n_top       = top_s;
                                n_bot       = bot_s;
                                n_d         = d_c[7:0];
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_W'(d_c[7:0]) * DIV_W'(SCALE);
                                div_req.divisor  = DIV_W'(cnt_c);
                                n_state = S_SPAN;
                            end
                        end
                        REQ_LOAD: begin
                            n_lim   = lim_s;
                            n_state = S_LOAD;
                        end
                        REQ_R2P: begin
                            n_state = S_RQ;
                        end
                        default: begin
                            if (i_req.priority_in <= PRI_W'(r_stored)) begin
                                n_p     = i_req.priority_in;
                                n_y     = '0;
                                n_state = S_SRD;
                            end else begin
                                n_res_row = ROW_W'(r_area_bot);
                                n_state   = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_SPAN: begin
                if (div_rsp.done) begin
                    n_span = span_c;
                    n_y    = '0;
                    n_fix  = 1'b0;
                    if (r_d != '0) begin
                        // The last banded row decides whether the top band folds down.
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(r_d - 1'b1) * DIV_W'(SCALE);
                        div_req.divisor  = span_c;
                        n_state = S_LAST;
                    end else begin
                        n_state = S_FILL;
                    end
                end
            end
            S_LAST: begin
                if (div_rsp.done) begin
                    n_fix   = (r_cnt == 4'(TOP_BAND)) &&
                              (div_rsp.quotient == DIV_W'(TOP_BAND - 1));
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_y == RW'(ROWS)) begin
                    n_area_top = r_top;
                    n_area_bot = (r_bot == RW'(ROWS)) ? RW'(ROWS - 1) : r_bot;
                    n_state    = S_DONE;
                end else if (r_y < r_top) begin
                    mem_we = 1'b1;
                    n_y    = r_y + 1'b1;
                end else if (r_y < r_bot) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(yt_c[7:0]) * DIV_W'(SCALE);
                    div_req.divisor  = r_span;
                    n_state = S_FDIV;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = PRI_W'(r_cnt);
                    n_y       = r_y + 1'b1;
                end
            end
            S_FDIV: begin
                if (div_rsp.done) begin
                    mem_we    = 1'b1;
                    mem_wdata = fval;
                    n_y       = r_y + 1'b1;
                    n_state   = S_FILL;
                end
            end
            S_LOAD: begin
                mem_addr = AW'(r_load_row);
                if (r_load_row < r_lim) begin
                    mem_we     = 1'b1;
                    mem_wdata  = PRI_W'(r_load_band);
                    n_load_row = r_load_row + 1'b1;
                end else begin
                    n_load_band = r_load_band + 1'b1;
                    if (r_load_band + 1'b1 >= 4'(BOUNDARY_COUNT)) begin
                        n_state = S_REST;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_REST: begin
                mem_addr = AW'(r_load_row);
                if (r_load_row < RW'(ROWS)) begin
                    mem_we     = 1'b1;
                    mem_wdata  = PRI_W'(BOUNDARY_COUNT);
                    n_load_row = r_load_row + 1'b1;
                end else begin
                    n_load_row  = '0;
                    n_load_band = '0;
                    n_state     = S_DONE;
                end
            end
            S_RQ: begin
                n_res_pri = mem_rdata;
                n_state   = S_DONE;
            end
            S_SRD: begin
                n_state = S_SCK;
            end
            S_SCK: begin
                if (mem_rdata == r_p) begin
                    n_res_row = ROW_W'(r_y);
                    n_state   = S_DONE;
                end else if (r_y >= r_area_bot) begin
                    n_res_row = ROW_W'(r_area_bot);
                    n_state   = S_DONE;
                end else begin
                    n_y     = r_y + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                if (push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_area_top  <= '0;
            r_area_bot  <= '0;
            r_stored    <= 4'(BOUNDARY_COUNT);
            r_load_row  <= '0;
            r_load_band <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_area_top  <= n_area_top;
            r_area_bot  <= n_area_bot;
            r_stored    <= n_stored;
            r_load_row  <= n_load_row;
            r_load_band <= n_load_band;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_y       <= n_y;
        r_top     <= n_top;
        r_bot     <= n_bot;
        r_lim     <= n_lim;
        r_cnt     <= n_cnt;
        r_d       <= n_d;
        r_span    <= n_span;
        r_fix     <= n_fix;
        r_p       <= n_p;
        r_res_pri <= n_res_pri;
        r_res_row <= n_res_row;
        r_res_st  <= n_res_st;
        if (push) begin
            r_out_pri <= r_res_pri;
            r_out_row <= r_res_row;
            r_out_st  <= r_res_st;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.priority_out = r_out_pri;
    assign o_rsp.row_out      = r_out_row;
    assign o_rsp.status       = r_out_st;
endmodule
`default_nettype wire

### src/pbt_checker.sv
// Port-level checker for the priority band table and its bind.
`default_nettype none
`include "priority_band_table_defines.svh"
module pbt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic [4:0] i_rsp_pri,
    input wire logic [7:0] i_rsp_row,
    input wire logic [1:0] i_rsp_status
);
    import pbt_pkg::*;

    logic [1:0] r_open;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = i_req_valid && i_req_ready;
    assign rsp_fire = i_rsp_valid && i_rsp_ready;

    // Count requests taken whose response has not been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {1'b0, req_fire} - {1'b0, rsp_fire};
        end
    end

    `PBT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_row) && $stable(i_rsp_pri))
    `PBT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, req_fire, !i_req_ready)
    `PBT_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, i_rsp_valid && i_rsp_status != ST_OK, i_rsp_pri == '0 && i_rsp_row == '0)
    `PBT_ASSERT_IMPL(a_no_orphan, i_clk, i_rst_n, i_rsp_valid, r_open != '0)
endmodule

bind priority_band_table pbt_checker u_pbt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_pri    (o_rsp.priority_out),
    .i_rsp_row    (o_rsp.row_out),
    .i_rsp_status (o_rsp.status)
);
`default_nettype wire

### verif/pbt_checker.sv
// Checker that predicts band table responses and compares them as they arrive.
`default_nettype none
module pbt_tb_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pbt_req_if        i_req,
    pbt_rsp_if        i_rsp,
    output int        o_fail_cnt,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pbt_pkg::*;

    localparam int ROWS = ROWS_DEF;

    typedef struct packed {
        logic [4:0] pri;
        logic [7:0] row;
        logic [1:0] status;
    } band_rsp_t;

    logic [4:0] band_tbl [ROWS];
    int         area_top, area_bot, band_cnt, fill_row, fill_band;
    band_rsp_t  rsp_fifo [$];

    function automatic int clip_rows(logic [7:0] v);
        return (v > ROWS) ? ROWS : int'(v);
    endfunction

    function automatic logic [4:0] table_at(int idx);
        return band_tbl[(idx >= ROWS) ? ROWS - 1 : idx];
    endfunction

    function automatic logic [1:0] build_bands(logic [3:0] cnt_in, logic keep,
                                               logic [7:0] top_in, logic [7:0] bot_in);
        int cnt, top, bot, span, y;
        cnt = keep ? band_cnt : int'(cnt_in);
        top = clip_rows(top_in);
        bot = clip_rows(bot_in);
        if (cnt == 0) return ST_ZERO;
        if (bot < top) return ST_ORDER;
        fill_row  = 0;
        fill_band = 0;
        band_cnt  = cnt;
        for (y = 0; y < top; y++) band_tbl[y] = '0;
        if (bot > top) begin
            span = ((bot - top) * SCALE) / cnt;
            if (span == 0) span = 1;
            for (y = top; y < bot; y++) band_tbl[y] = 5'(1 + ((y - top) * SCALE) / span);
            // turn the trailing top band down one
            if (cnt == TOP_BAND) begin
                y = bot;
                while (y > top && band_tbl[y-1] == 5'(TOP_BAND)) begin
                    band_tbl[y-1] = 5'(TOP_BAND - 1);
                    y--;
                end
            end
        end
        for (y = bot; y < ROWS; y++) band_tbl[y] = 5'(cnt);
        area_top = top;
        area_bot = (bot == ROWS) ? ROWS - 1 : bot;
        return ST_OK;
    endfunction

    function automatic void load_boundary(logic [7:0] bnd);
        int lim;
        lim = clip_rows(bnd);
        while (fill_row < lim) begin
            band_tbl[fill_row] = 5'(fill_band);
            fill_row++;
        end
        fill_band++;
        if (fill_band >= BOUNDARY_COUNT) begin
            while (fill_row < ROWS) begin
                band_tbl[fill_row] = 5'(BOUNDARY_COUNT);
                fill_row++;
            end
            fill_row  = 0;
            fill_band = 0;
        end
    endfunction

    function automatic logic [4:0] row_band(logic signed [9:0] r);
        int y;
        y = int'(r);
        if (y < area_top) return table_at(area_top);
        if (y > area_bot) return table_at(area_bot);
        return table_at(y);
    endfunction

    function automatic logic [7:0] band_first_row(logic [4:0] p);
        if (p <= band_cnt)
            for (int y = 0; y <= area_bot && y < ROWS; y++)
                if (band_tbl[y] == p) return 8'(y);
        return 8'(area_bot);
    endfunction

    always @(posedge i_clk) begin
        band_rsp_t exp_r;
        if (!i_rst_n) begin
            area_top   = 0;
            area_bot   = 0;
            band_cnt   = 14;
            fill_row   = 0;
            fill_band  = 0;
            o_fail_cnt = 0;
            rsp_fifo.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_fifo.size() == 0) begin
                    $error("response with no request outstanding");
                    o_fail_cnt++;
                end else begin
                    exp_r = rsp_fifo.pop_front();
                    if (i_rsp.priority_out !== exp_r.pri) begin
                        $error("priority_out: expected %0d, got %0d", exp_r.pri,
                               i_rsp.priority_out);
                        o_fail_cnt++;
                    end
                    if (i_rsp.row_out !== exp_r.row) begin
                        $error("row_out: expected %0d, got %0d", exp_r.row, i_rsp.row_out);
                        o_fail_cnt++;
                    end
                    if (i_rsp.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, i_rsp.status);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                exp_r = '0;
                case (i_req.req_type)
                    REQ_BUILD: exp_r.status = build_bands(i_req.band_count, i_req.keep_count,
                                                          i_req.top_row, i_req.bottom_row);
                    REQ_LOAD:  load_boundary(i_req.boundary);
                    REQ_R2P:   exp_r.pri = row_band(i_req.row_in);
                    default:   exp_r.row = band_first_row(i_req.priority_in);
                endcase
                rsp_fifo = {rsp_fifo, exp_r};
            end
        end
        o_pending = rsp_fifo.size();
    end
endmodule
`default_nettype wire

### verif/priority_band_table_tb.sv
// Top of the band table testbench: clock, reset, request stimulus and verdict.
`default_nettype none
module priority_band_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pbt_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt, pending;
    bit   quiet = 1'b0;
    int   sent = 0;
    // stimulus-side view of what keeps queries legal
    bit   tbl_written = 1'b0;
    int   stim_cnt = 14;
    int   loads_done = 0;

    pbt_req_if req_ch ();
    pbt_rsp_if rsp_ch ();

    priority_band_table dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch), .o_rsp(rsp_ch));
    pbt_tb_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch), .i_rsp(rsp_ch),
                        .o_fail_cnt(fail_cnt), .o_pending(pending));

    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_req(logic [1:0] kind, logic [3:0] cnt, logic keep, logic [7:0] top,
                            logic [7:0] bot, logic [7:0] bnd, logic [9:0] row,
                            logic [4:0] pri);
        int c;
        if (kind == REQ_BUILD) begin
            c = keep ? stim_cnt : int'(cnt);
            if (c != 0 && ((bot > 200) ? 200 : bot) >= ((top > 200) ? 200 : top)) begin
                stim_cnt    = c;
                tbl_written = 1'b1;
                loads_done  = 0;
            end
        end else if (kind == REQ_LOAD) begin
            loads_done++;
            if (loads_done == BOUNDARY_COUNT) begin
                loads_done  = 0;
                tbl_written = 1'b1;
            end
        end
        if (!quiet && $urandom_range(99) < 19) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.req_type    <= kind;
        req_ch.band_count  <= cnt;
        req_ch.keep_count  <= keep;
        req_ch.top_row     <= top;
        req_ch.bottom_row  <= bot;
        req_ch.boundary    <= bnd;
        req_ch.row_in      <= row;
        req_ch.priority_in <= pri;
        req_ch.valid       <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_build(logic [3:0] cnt, logic keep, logic [7:0] top, logic [7:0] bot);
        send_req(REQ_BUILD, cnt, keep, top, bot, 8'($urandom), 10'($urandom), 5'($urandom));
    endtask

    task automatic send_load(logic [7:0] bnd);
        send_req(REQ_LOAD, 4'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), bnd,
                 10'($urandom), 5'($urandom));
    endtask

    task automatic send_query(logic [1:0] kind, logic [9:0] row, logic [4:0] pri);
        send_req(kind, 4'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 row, pri);
    endtask

    // A run of n non-decreasing boundaries in random steps, occasionally swapped for random bytes.
    task automatic send_load_run(int n);
        int b;
        b = 0;
        for (int k = 0; k < n; k++) begin
            b = b + $urandom_range(0, 30);
            if (b > 255) b = 255;
            send_load(($urandom_range(9) == 0) ? 8'($urandom) : 8'(b));
        end
    endtask

    // response side: random stalls, one long hold-off partway through
    initial begin
        int cyc, hold;
        cyc  = 0;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 30_000) hold = 3000;
            if (hold > 0) begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end else if (quiet) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= 19);
            end
        end
    end

    initial begin
        int pick, waited;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_BUILD;
        req_ch.band_count  <= '0;
        req_ch.keep_count  <= 1'b0;
        req_ch.top_row     <= '0;
        req_ch.bottom_row  <= '0;
        req_ch.boundary    <= '0;
        req_ch.row_in      <= '0;
        req_ch.priority_in <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two rejected builds first, while the table is still unwritten
        send_build(4'd0, 1'b0, 8'd0, 8'd200);
        send_build(4'd5, 1'b0, 8'd120, 8'd40);
        send_build(4'd0, 1'b1, 8'd0, 8'd10);
        send_build(4'd14, 1'b0, 8'd0, 8'd200);
        send_query(REQ_R2P, 10'h200, 5'd0);
        send_query(REQ_R2P, 10'h1FF, 5'd0);
        send_query(REQ_R2P, 10'd199, 5'd0);
        send_query(REQ_P2R, 10'd0, 5'd31);
        send_query(REQ_P2R, 10'd0, 5'd14);
        send_build(4'd15, 1'b0, 8'd0, 8'd200);
        send_query(REQ_P2R, 10'd0, 5'd15);
        send_query(REQ_P2R, 10'd0, 5'd14);
        send_build(4'd3, 1'b1, 8'd250, 8'd255);
        send_query(REQ_R2P, 10'd100, 5'd0);
        send_build(4'd15, 1'b0, 8'd190, 8'd191);
        send_build(4'd9, 1'b1, 8'd30, 8'd150);
        send_query(REQ_P2R, 10'd0, 5'd0);
        send_load_run(3);
        send_build(4'd7, 1'b0, 8'd10, 8'd60);
        send_load_run(BOUNDARY_COUNT);
        send_query(REQ_R2P, 10'd5, 5'd0);
        send_query(REQ_P2R, 10'd0, 5'd13);

        while (sent < 1500) begin
            quiet = (sent >= 600 && sent < 800);
            pick  = $urandom_range(99);
            if (pick < 8) begin
                if ($urandom_range(9) < 8) begin
                    pick = $urandom_range(0, 200);
                    send_build(4'($urandom), 1'($urandom), 8'(pick),
                               8'($urandom_range(pick, 255)));
                end else begin
                    send_build(4'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
                end
            end else if (pick < 16) begin
                send_load_run(($urandom_range(4) == 0) ? $urandom_range(1, 13)
                                                       : BOUNDARY_COUNT);
            end else if (!tbl_written) begin
                send_build(4'($urandom_range(1, 15)), 1'b0, 8'd0, 8'd200);
            end else if (pick < 60) begin
                send_query(REQ_R2P, ($urandom_range(1) == 0) ? 10'($urandom_range(0, 210))
                                                             : 10'($urandom), 5'd0);
            end else begin
                send_query(REQ_P2R, 10'd0, ($urandom_range(3) == 0) ? 5'($urandom)
                                                                  : 5'($urandom_range(0, 15)));
            end
        end
        req_ch.valid <= 1'b0;
        quiet = 1'b0;

        waited = 0;
        while (pending != 0 && waited < 200_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
